/* src/ils_pkg.sv */
// Package for the indexed list store: operation and status codes, word layout
// constants, and the command and status structs between controller and datapath.
// Depends on nothing.
package ils_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 7;

  localparam int IN_OP_LSB   = 0;
  localparam int IN_POS_LSB  = IN_OP_LSB + OP_W;
  localparam int IN_VAL_LSB  = IN_POS_LSB + POS_W;
  localparam int IN_USED_W   = IN_VAL_LSB + VAL_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_USED_W  = ST_W + VAL_W + LEN_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic capture;
    logic stat_load;
    logic rd_pos;
    logic rd_shift;
    logic ptr_load;
    logic ptr_step;
    logic wr_val;
    logic count_inc;
    logic count_dec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ST_W-1:0] code;
    logic            need_shift;
    logic            last;
    logic            out_free;
  } stat_t;

endpackage

/* src/ils_ctrl.sv */
// Controller state machine of the indexed list store.
// Depends on ils_pkg; drives the command struct of ils_dp.
module ils_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ils_pkg::stat_t st,
  output ils_pkg::cmd_t  cmd
);
  import ils_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmd.stat_load = 1'b1;
        state_nxt     = S_RES;
        if (st.code == ST_DONE) begin
          case (st.op)
            OP_READ: begin
              cmd.rd_pos = 1'b1;
            end
            OP_INSERT: begin
              if (st.need_shift) begin
                cmd.ptr_load = 1'b1;
                state_nxt    = S_SHIFT;
              end else begin
                cmd.wr_val    = 1'b1;
                cmd.count_inc = 1'b1;
              end
            end
            OP_DELETE: begin
              if (st.need_shift) begin
                cmd.ptr_load = 1'b1;
                state_nxt    = S_SHIFT;
              end else begin
                cmd.count_dec = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd.rd_shift = 1'b1;
        if (st.last) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.ptr_step = 1'b1;
        end
      end
      S_DRAIN: begin
        if (st.op == OP_INSERT) begin
          state_nxt = S_FIN;
        end else begin
          cmd.count_dec = 1'b1;
          state_nxt     = S_RES;
        end
      end
      S_FIN: begin
        cmd.wr_val    = 1'b1;
        cmd.count_inc = 1'b1;
        state_nxt     = S_RES;
      end
      S_RES: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/ils_dp.sv */
// Datapath of the indexed list store: request registers, entry memory,
// move pointer, entry count and the output word register.
// Depends on ils_pkg; driven by the command struct from ils_ctrl.
module ils_dp #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ils_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ils_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  ils_pkg::cmd_t                  cmd,
  output ils_pkg::stat_t                 st
);
  import ils_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > POS_W) ? CW : POS_W;

  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [ST_W-1:0]  stat_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [AW-1:0]    ptr_r;
  logic [AW-1:0]    ptr_nxt;
  logic [AW-1:0]    raddr_r;
  logic [VAL_W-1:0] rdata_r;
  logic             pend_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [ST_W-1:0]  out_status_r;
  logic [VAL_W-1:0] out_rdata_r;
  logic [LEN_W-1:0] out_len_r;
  logic [VAL_W-1:0] mem_r [DEPTH];

  logic [KW-1:0]    pos_k;
  logic [KW-1:0]    cnt_k;
  logic [KW-1:0]    cnt_m1;
  logic [AW-1:0]    pos_a;
  logic [ST_W-1:0]  code;
  logic             need_shift;
  logic             last;
  logic             re;
  logic [AW-1:0]    ra;
  logic             we;
  logic [AW-1:0]    wa;
  logic [VAL_W-1:0] wd;
  logic [AW-1:0]    waddr;

  assign pos_k  = KW'(pos_r);
  assign cnt_k  = KW'(count_r);
  assign cnt_m1 = cnt_k - KW'(1);
  assign pos_a  = pos_k[AW-1:0];

  always_comb begin
    code       = ST_RANGE;
    need_shift = 1'b0;
    last       = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (pos_k > cnt_k) begin
          code = ST_RANGE;
        end else if (cnt_k == KW'(DEPTH)) begin
          code = ST_FULL;
        end else begin
          code = ST_DONE;
        end
        need_shift = pos_k < cnt_k;
        last       = ptr_r == pos_a;
      end
      OP_DELETE: begin
        code       = (pos_k < cnt_k) ? ST_DONE : ST_RANGE;
        need_shift = (pos_k + KW'(1)) < cnt_k;
        last       = ptr_r == cnt_m1[AW-1:0];
      end
      OP_READ: begin
        code = (pos_k < cnt_k) ? ST_DONE : ST_RANGE;
      end
      default: begin
        code = ST_RANGE;
      end
    endcase
  end

  assign st.op         = op_r;
  assign st.code       = code;
  assign st.need_shift = need_shift;
  assign st.last       = last;
  assign st.out_free   = !out_valid_r || out_tready;

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_load) begin
      ptr_nxt = (op_r == OP_INSERT) ? cnt_m1[AW-1:0] : pos_a + AW'(1);
    end else if (cmd.ptr_step) begin
      ptr_nxt = (op_r == OP_INSERT) ? ptr_r - AW'(1) : ptr_r + AW'(1);
    end
  end

  assign re    = cmd.rd_pos || cmd.rd_shift;
  assign ra    = cmd.rd_pos ? pos_a : ptr_r;
  assign waddr = (op_r == OP_INSERT) ? raddr_r + AW'(1) : raddr_r - AW'(1);
  assign we    = pend_r || cmd.wr_val;
  assign wa    = pend_r ? waddr : pos_a;
  assign wd    = pend_r ? rdata_r : val_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.count_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= cmd.rd_shift;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.capture) begin
      op_r  <= in_tdata[IN_OP_LSB +: OP_W];
      pos_r <= in_tdata[IN_POS_LSB +: POS_W];
      val_r <= in_tdata[IN_VAL_LSB +: VAL_W];
    end
    if (cmd.stat_load) begin
      stat_r <= code;
    end
    if (cmd.out_load) begin
      out_status_r <= stat_r;
      out_rdata_r  <= (op_r == OP_READ && stat_r == ST_DONE) ? rdata_r : '0;
      out_len_r    <= cnt_k[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem_r[ra];
      raddr_r <= ra;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_len_r, out_rdata_r, out_status_r};

endmodule

/* src/indexed_list_store_unit.sv */
// Top level of the indexed list store: an ordered list of signed 32-bit entries
// with insert, delete and read at a position. Depends on ils_pkg, ils_ctrl, ils_dp.
//
// A request word enters on the in_ channel; exactly one result word leaves on the
// out_ channel for each request, in order. A request is taken only while the
// controller is idle, and the next one is taken as soon as the previous result
// sits in the output register, even if the receiver has not taken it yet.
// A read, a rejected request, an insert at the end or a delete of the last entry
// goes from the decode state straight to the result state. An insert at
// position p moves count - p entries and a delete at position p moves
// count - p - 1 entries, through a shift state and then a drain state.
// One entry moves per cycle through the single read and single write port of the
// entry memory, and one request is in flight at a time.
// When the receiver stalls, the result word holds on out_tdata and the next
// result waits in the controller until the output register is free.
// Reset empties the list and drops any pending result; entry contents are not
// cleared.
module indexed_list_store_unit #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: op (2), position (7), value (32), zero fill.
  input  logic [ils_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: status (2), read_value (32), length (7), zero fill.
  output logic [ils_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ils_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ils_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

/* src/ils_chk.sv */
// Port checker for the indexed list store and its bind to the top level.
// Depends on ils_pkg and indexed_list_store_unit.
module ils_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ils_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ils_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[ST_W-1:0] != ST_DONE |-> out_tdata[ST_W +: VAL_W] == '0)
    else $error("read value not zero on a failed request");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result word appeared one cycle after a request");

endmodule

bind indexed_list_store_unit ils_chk u_ils_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/tb_indexed_list_store_unit.sv */
// Testbench for indexed_list_store_unit: directed and random insert, delete, read and unused-op
// words under several idle and stall patterns, checked against an in-bench list model.
// Depends on ils_pkg and indexed_list_store_unit.
module tb_indexed_list_store_unit;
  import ils_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_ITEMS = 450;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               send_idle;
    int               recv_stall;
  } list_request_t;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  list_request_t pending_requests[$];
  list_result_t  expected_results[$];
  logic [VAL_W-1:0] model_entries [LIST_DEPTH];
  int model_len = 0;
  int gen_len = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  indexed_list_store_unit #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [IN_TDATA_W-1:0] pack_request(input list_request_t req);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_OP_LSB +: OP_W] = req.op;
    word[IN_POS_LSB +: POS_W] = req.pos;
    word[IN_VAL_LSB +: VAL_W] = req.val;
    return word;
  endfunction

  function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    list_result_t res;
    int i;
    int p;
    p = int'(pos);
    res.status = ST_RANGE;
    res.read_value = '0;
    case (op)
      OP_INSERT: begin
        if (p > model_len) begin
          res.status = ST_RANGE;
        end else if (model_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = model_len; i > p; i--) model_entries[i] = model_entries[i-1];
          model_entries[p] = val;
          model_len++;
          res.status = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (p < model_len) begin
          for (i = p; i + 1 < model_len; i++) model_entries[i] = model_entries[i+1];
          model_len--;
          res.status = ST_DONE;
        end
      end
      OP_READ: begin
        if (p < model_len) begin
          res.read_value = model_entries[p];
          res.status = ST_DONE;
        end
      end
      default: res.status = ST_RANGE;
    endcase
    res.length = model_len[LEN_W-1:0];
    return res;
  endfunction

  task automatic add_request(input logic [OP_W-1:0] op, input int pos,
                             input logic [VAL_W-1:0] val, input int send_idle,
                             input int recv_stall);
    list_request_t req;
    req.op = op;
    req.pos = pos[POS_W-1:0];
    req.val = val;
    req.send_idle = send_idle;
    req.recv_stall = recv_stall;
    pending_requests.push_back(req);
    if (op == OP_INSERT && pos <= gen_len && gen_len < LIST_DEPTH) gen_len++;
    else if (op == OP_DELETE && pos < gen_len) gen_len--;
  endtask

  task automatic add_random_request(input int mode, input int send_idle,
                                    input int recv_stall);
    logic [OP_W-1:0] op;
    logic [VAL_W-1:0] val;
    int pos;
    int r;
    int ins_pct;
    int del_pct;
    case ($urandom_range(7))
      0: val = 32'h7fff_ffff;
      1: val = 32'h8000_0000;
      2: val = 32'hffff_ffff;
      3: val = '0;
      default: val = $urandom;
    endcase
    if (mode == 3) begin
      op = OP_W'($urandom_range(3));
      pos = $urandom_range(127);
    end else begin
      ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 40;
      del_pct = (mode == 0) ? 5 : (mode == 1) ? 70 : 30;
      r = $urandom_range(99);
      if (r < ins_pct) op = OP_INSERT;
      else if (r < ins_pct + del_pct) op = OP_DELETE;
      else op = OP_READ;
      if ($urandom_range(9) == 0) begin
        pos = $urandom_range(127);
      end else if (op == OP_INSERT) begin
        pos = ($urandom_range(3) == 0) ? gen_len : $urandom_range(gen_len);
      end else begin
        pos = (gen_len > 0) ? $urandom_range(gen_len - 1) : 0;
      end
    end
    add_request(op, pos, val, send_idle, recv_stall);
  endtask

  task automatic report_mismatch(input string field, input logic [VAL_W-1:0] want_v,
                                 input logic [VAL_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0h, got %0h", field, want_v, got_v);
  endtask

  always @(posedge clk) begin : driver
    list_request_t next_req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_requests.size() != 0 &&
          $urandom_range(99) >= pending_requests[0].send_idle) begin
        next_req = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= pack_request(next_req);
        recv_stall_pct <= next_req.recv_stall;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    list_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", '0, out_tdata[VAL_W-1:0]);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[0 +: ST_W] !== want.status)
            report_mismatch("status", VAL_W'(want.status), VAL_W'(out_tdata[0 +: ST_W]));
          if (out_tdata[ST_W +: VAL_W] !== want.read_value)
            report_mismatch("read_value", want.read_value, out_tdata[ST_W +: VAL_W]);
          if (out_tdata[ST_W + VAL_W +: LEN_W] !== want.length)
            report_mismatch("length", VAL_W'(want.length),
                            VAL_W'(out_tdata[ST_W + VAL_W +: LEN_W]));
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(in_tdata[IN_OP_LSB +: OP_W],
                                                 in_tdata[IN_POS_LSB +: POS_W],
                                                 in_tdata[IN_VAL_LSB +: VAL_W]));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("indexed_list_store_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    int send_idle;
    int recv_stall;
    int mode;
    int seg_left;
    int n;
    for (n = 0; n < LIST_DEPTH; n++) model_entries[n] = '0;

    add_request(OP_READ, 0, 32'h1234_5678, 0, 0);
    add_request(OP_DELETE, 0, '0, 0, 0);
    add_request(OP_UNUSED, 0, '0, 0, 0);
    add_request(OP_INSERT, 1, 32'h1111_1111, 0, 0);
    add_request(OP_INSERT, 0, 32'h7fff_ffff, 0, 0);
    add_request(OP_INSERT, 0, 32'h8000_0000, 0, 0);
    add_request(OP_INSERT, 2, 32'hffff_ffff, 0, 0);
    add_request(OP_INSERT, 1, 32'h0000_0000, 0, 0);
    add_request(OP_INSERT, 127, 32'h0bad_0bad, 0, 0);
    add_request(OP_READ, 0, '0, 0, 0);
    add_request(OP_READ, 1, '0, 0, 0);
    add_request(OP_READ, 2, '0, 0, 0);
    add_request(OP_READ, 3, '0, 0, 0);
    add_request(OP_READ, 4, '0, 0, 0);
    add_request(OP_DELETE, 127, '0, 0, 0);
    add_request(OP_DELETE, 1, '0, 0, 0);
    add_request(OP_DELETE, 2, '0, 0, 0);
    add_request(OP_READ, 0, '0, 0, 0);
    add_request(OP_READ, 1, '0, 0, 0);
    add_request(OP_UNUSED, 127, 32'hffff_ffff, 0, 0);
    add_request(OP_INSERT, 2, 32'h5a5a_5a5a, 0, 0);
    add_request(OP_DELETE, 0, '0, 0, 0);
    add_request(OP_READ, 64, '0, 0, 0);

    for (phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1) ? 85 : (phase == 3) ? 9 : 0;
      recv_stall = (phase == 2) ? 85 : (phase == 3) ? 9 : 0;
      seg_left = 0;
      mode = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(120, 20);
          case ($urandom_range(99) / 10)
            0, 1, 2: mode = 0;
            3, 4: mode = 1;
            9: mode = 3;
            default: mode = 2;
          endcase
        end
        seg_left--;
        add_random_request(mode, send_idle, recv_stall);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("indexed_list_store_unit verification clean");
    end else begin
      $display("indexed_list_store_unit verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ils_pkg.sv
src/ils_ctrl.sv
src/ils_dp.sv
src/indexed_list_store_unit.sv
src/ils_chk.sv
sim/tb_indexed_list_store_unit.sv
